// ===== sv/hcb_pkg.sv =====
// Shared types, constants and partial-product functions for the crossfade blender.
package hcb_pkg;

    localparam int unsigned PIX_W    = 16;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned LVL_W    = 7;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned FRAC_W   = 17;

    localparam logic [CFG_IDX_W-1:0] REG_FADE_FRACTION  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_SIX_BITS = 8'd1;

    localparam logic [WORD_W-1:0] MASK_565 = 32'hFC1F03E0;
    localparam logic [WORD_W-1:0] MASK_555 = 32'hF81F07C0;
    localparam logic [FRAC_W-1:0] FULL_FRACTION = 17'h10000;

    typedef struct packed {
        logic [LVL_W-1:0] fg_weight;
        logic [LVL_W-1:0] bg_weight;
        logic             six;
    } cfg_t;

    function automatic logic [WORD_W-1:0] low_word(input logic [LVL_W-1:0] lvl,
                                                  input logic [7:0] c,
                                                  input logic six);
        logic [11:0] pb;
        logic [14:0] pg;
        logic [11:0] b;
        logic [14:0] g;
        pb = 12'(c[4:0]) * 12'(lvl);
        pg = 15'(c & 8'hE0) * 15'(lvl);
        if (six) begin
            b = pb >> 1;
            g = pg >> 6;
        end else begin
            b = pb;
            g = pg >> 5;
        end
        return WORD_W'(b) | (WORD_W'(g) << 21);
    endfunction

    function automatic logic [WORD_W-1:0] high_word(input logic [LVL_W-1:0] lvl,
                                                   input logic [7:0] c,
                                                   input logic six);
        logic [10:0] g;
        logic [14:0] pr;
        logic [WORD_W-1:0] r;
        if (six) begin
            g  = (11'(c & 8'h07) * 11'(lvl)) << 2;
            pr = 15'(c & 8'hF8) * 15'(lvl);
            r  = WORD_W'(pr >> 3) << 10;
        end else begin
            g  = (11'(c & 8'h03) * 11'(lvl)) << 3;
            pr = 15'(c & 8'h7C) * 15'(lvl);
            r  = WORD_W'(pr >> 3) << 11;
        end
        return r | (WORD_W'(g) << 21);
    endfunction

endpackage

// ===== sv/hcb_cfg.sv =====
// Configuration registers: fade fraction turned into weights, and pixel format.
module hcb_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hcb_pkg::CFG_DATA_W-1:0] cfg_data,
    output hcb_pkg::cfg_t                  cfg_out
);

    hcb_pkg::cfg_t cfg_reg, cfg_next;
    logic [hcb_pkg::FRAC_W-1:0] frac;
    logic [hcb_pkg::FRAC_W-1:0] bg_rem;

    assign cfg_ready = 1'b1;
    assign frac      = cfg_data[hcb_pkg::FRAC_W-1:0];
    assign bg_rem    = hcb_pkg::FULL_FRACTION - frac;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                hcb_pkg::REG_FADE_FRACTION: begin
                    if (frac >= hcb_pkg::FULL_FRACTION) begin
                        cfg_next.fg_weight = 7'd64;
                        cfg_next.bg_weight = 7'd0;
                    end else begin
                        cfg_next.fg_weight = 7'(frac[15:10]);
                        cfg_next.bg_weight = bg_rem[16:10];
                    end
                end
                hcb_pkg::REG_GREEN_SIX_BITS: begin
                    cfg_next.six = cfg_data[0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fg_weight <= 7'd0;
            cfg_reg.bg_weight <= 7'd64;
            cfg_reg.six       <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_out = cfg_reg;

endmodule

// ===== sv/hcb_pipe.sv =====
// Three-stage blend pipeline: partial products, masked sum, fold and shift.
module hcb_pipe (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  hcb_pkg::cfg_t             cfg,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [hcb_pkg::PIX_W-1:0] s_new_pixel,
    input  logic [hcb_pkg::PIX_W-1:0] s_old_pixel,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [hcb_pkg::PIX_W-1:0] m_blended_pixel
);

    logic adv;

    logic                       v1_reg, v1_next;
    logic [hcb_pkg::WORD_W-1:0] w0_reg, w1_reg, w2_reg, w3_reg;
    logic [hcb_pkg::WORD_W-1:0] w0_next, w1_next, w2_next, w3_next;

    logic                       v2_reg, v2_next;
    logic [hcb_pkg::WORD_W-1:0] sum_reg, sum_next;

    logic                       v3_reg, v3_next;
    logic [hcb_pkg::PIX_W-1:0]  pix_reg, pix_next;
    logic [hcb_pkg::WORD_W-1:0] folded;

    assign adv     = !v3_reg || m_ready;
    assign s_ready = adv;

    always_comb begin
        v1_next = s_valid;
        w0_next = hcb_pkg::low_word(cfg.fg_weight, s_new_pixel[7:0], cfg.six);
        w1_next = hcb_pkg::high_word(cfg.fg_weight, s_new_pixel[15:8], cfg.six);
        w2_next = hcb_pkg::low_word(cfg.bg_weight, s_old_pixel[7:0], cfg.six);
        w3_next = hcb_pkg::high_word(cfg.bg_weight, s_old_pixel[15:8], cfg.six);
    end

    always_comb begin
        v2_next  = v1_reg;
        sum_next = (w0_reg + w1_reg + w2_reg + w3_reg)
                 & (cfg.six ? hcb_pkg::MASK_565 : hcb_pkg::MASK_555);
    end

    always_comb begin
        v3_next  = v2_reg;
        folded   = {sum_reg[31:16], sum_reg[15:0] | sum_reg[31:16]};
        pix_next = cfg.six ? folded[20:5] : folded[21:6];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w0_reg  <= w0_next;
            w1_reg  <= w1_next;
            w2_reg  <= w2_next;
            w3_reg  <= w3_next;
            sum_reg <= sum_next;
            pix_reg <= pix_next;
        end
    end

    assign m_valid         = v3_reg;
    assign m_blended_pixel = pix_reg;

    a_out_from_stage2: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v3_reg) |-> $past(v2_reg))
        else $error("result appeared without an item in the sum stage");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !m_ready) |=> ($stable(v1_reg) && $stable(v2_reg)))
        else $error("pipeline moved during output stall");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted item missing from first stage");

endmodule

// ===== sv/hicolor_crossfade_blend_top.sv =====
// Top level of the high-color crossfade blender.
//
//   channel  dir  handshake              payload
//   s_       in   s_valid / s_ready      s_new_pixel[15:0], s_old_pixel[15:0]
//   m_       out  m_valid / m_ready      m_blended_pixel[15:0]
//   cfg_     in   cfg_valid / cfg_ready  cfg_index[7:0], cfg_data[31:0]
//
// One item per clock unless the output stalls (three register stages).
// Stages: partial-product words, masked 32-bit sum, fold and format shift.
// Synchronous active-low reset clears valid bits; fade 0, 565 format.
// A stall (m_valid high, m_ready low) freezes all stages together and drops s_ready.
// Config writes are taken every cycle; new weights apply to items accepted after
// the write edge, a new format at once to items in flight as well. The user must
// write only with the pipeline empty; the block itself does not enforce this.
module hicolor_crossfade_blend_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [hcb_pkg::PIX_W-1:0]      s_new_pixel,
    input  logic [hcb_pkg::PIX_W-1:0]      s_old_pixel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hcb_pkg::PIX_W-1:0]      m_blended_pixel,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hcb_pkg::CFG_DATA_W-1:0] cfg_data
);

    hcb_pkg::cfg_t cfg;

    hcb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    hcb_pipe u_pipe (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_new_pixel     (s_new_pixel),
        .s_old_pixel     (s_old_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_blended_pixel (m_blended_pixel)
    );

endmodule
